// ===== rtl/core/pid_position_controller_macros.svh =====
// Assertion macros for the PID position controller.
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define PIDPC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("pid_position_controller assertion failed");
// Check that a condition is followed in the next cycle by another.
`define PIDPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pid_position_controller sequencing assertion failed");
`else
`define PIDPC_ASSERT(lbl, clk, rstn, prop)
`define PIDPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/pidpc_pkg.sv =====
// Shared types, constants and fixed-point helpers of the PID position controller.
`default_nettype none

package pidpc_pkg;

	localparam int GAIN_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS  = 16;

	localparam int DIST_W     = 16;
	localparam int GAIN_W     = 24;
	localparam int TICKS_W    = 24;
	localparam int OUT_W      = 48;
	localparam int CFG_DATA_W = 24;

	localparam int PROD_W = DIST_W + GAIN_W;
	localparam int SHL    = (GAIN_FRAC_BITS < OUT_FRAC_BITS) ? OUT_FRAC_BITS - GAIN_FRAC_BITS : 0;
	localparam int SHR    = (GAIN_FRAC_BITS > OUT_FRAC_BITS) ? GAIN_FRAC_BITS - OUT_FRAC_BITS : 0;
	localparam int MAG_W  = PROD_W + SHL;
	localparam int TERM_W = MAG_W + 1;
	localparam int ACC_W  = ((TERM_W > OUT_W) ? TERM_W : OUT_W) + 2;
	localparam int CNT_W  = $clog2(MAG_W + 1);

	localparam logic [DIST_W-1:0] SETPOINT_RST = 16'd30;
	localparam logic [GAIN_W-1:0] KP_RST       = 24'd65536;
	localparam logic [GAIN_W-1:0] KI_RST       = 24'd655;
	localparam logic [GAIN_W-1:0] KD_RST       = 24'd262144;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CFG_SETPOINT = 2'd0,
		CFG_KP       = 2'd1,
		CFG_KI       = 2'd2,
		CFG_KD       = 2'd3
	} cfg_idx_t;

	// Bring a gain product to the output fraction bits, truncating.
	function automatic logic [MAG_W-1:0] conv_mag(input logic [PROD_W-1:0] prod);
		logic [MAG_W-1:0] ext;
		ext = MAG_W'(prod);
		return (ext << SHL) >> SHR;
	endfunction

	// Apply a sign to a magnitude.
	function automatic logic signed [TERM_W-1:0] to_term(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic signed [TERM_W-1:0] t;
		t = signed'({1'b0, mag});
		return neg ? -t : t;
	endfunction

	// Clamp to the signed output range.
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > ACC_W'(OUT_MAX)) begin
			r = OUT_MAX;
		end else if (v < ACC_W'(OUT_MIN)) begin
			r = OUT_MIN;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidpc_ifs.sv =====
// Valid/ready channel interfaces for measurement requests and drive results.
`default_nettype none

interface pidpc_in_if;
	logic                          valid;
	logic                          ready;
	logic [pidpc_pkg::DIST_W-1:0]  measured_distance;
	logic [pidpc_pkg::TICKS_W-1:0] elapsed_ticks;

	modport source (output valid, output measured_distance, output elapsed_ticks, input ready);
	modport sink (input valid, input measured_distance, input elapsed_ticks, output ready);
endinterface

interface pidpc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pidpc_pkg::OUT_W-1:0] drive_value;
	logic                               zero_interval;

	modport source (output valid, output drive_value, output zero_interval, input ready);
	modport sink (input valid, input drive_value, input zero_interval, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pid_position_controller.sv =====
// Top level of the PID position controller with derivative on measurement.
//
// Usage:
//   meas carries one request per measurement: measured_distance and the
//   elapsed_ticks since the previous one. cmd returns exactly one result per
//   request: drive_value = P + I + D (signed, 16 fraction bits, saturated to
//   48 bits) and zero_interval, set when elapsed_ticks was zero.
//   Gains and setpoint are written through cfg_wr_en/cfg_index/cfg_data while
//   no request is in flight.
// Sequencing:
//   An accepted request steps through ST_MUL_P, ST_MUL_I, ST_MUL_D and
//   ST_DIV_LOAD, then through ST_DIV unless elapsed_ticks is zero (the
//   derivative division in the 40-step bit-serial divider), and ends in
//   ST_SUM. The three gain products go one after another through a single
//   multiplier. meas.ready is high only while the sequencer is idle, so a
//   new request waits until the previous one has left ST_SUM.
// Reset:
//   arst_n clears the integral and the previous distance to zero and loads
//   the default setpoint and gains.
// Stalls:
//   The result sits in an output register until cmd.ready takes it; a new
//   request is accepted meanwhile and waits at its final sum if the
//   register is still full.
`default_nettype none
`include "pid_position_controller_macros.svh"

module pid_position_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	pidpc_in_if.sink                              meas,
	pidpc_out_if.source                           cmd,
	input  wire logic                             cfg_wr_en,
	input  wire pidpc_pkg::cfg_idx_t              cfg_index,
	input  wire logic [pidpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pidpc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_DIV_LOAD,
		ST_DIV,
		ST_SUM
	} state_t;

	state_t state_q;

	// Configuration
	logic [DIST_W-1:0] setpoint_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;

	// Persistent controller state
	logic signed [OUT_W-1:0] integral_q;
	logic [DIST_W-1:0]       prev_q;

	// Per-request working registers
	logic [DIST_W-1:0]        meas_q;
	logic [TICKS_W-1:0]       ticks_q;
	logic                     err_neg_q;
	logic [DIST_W-1:0]        err_mag_q;
	logic                     diff_neg_q;
	logic [DIST_W-1:0]        diff_mag_q;
	logic signed [TERM_W-1:0] p_q;
	logic signed [TERM_W-1:0] d_q;

	// Output register
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] drive_q;
	logic                    zero_q;

	logic                     accept;
	logic signed [DIST_W:0]   err_in;
	logic signed [DIST_W:0]   diff_in;
	logic [DIST_W-1:0]        mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic [PROD_W-1:0]        prod;
	logic [MAG_W-1:0]         prod_mag;
	logic signed [TERM_W-1:0] i_term;
	logic signed [ACC_W-1:0]  integral_next;
	logic signed [ACC_W-1:0]  total;
	logic                     div_start;
	logic                     div_done;
	logic [MAG_W-1:0]         quotient;
	logic                     out_free;

	assign meas.ready = (state_q == ST_IDLE);
	assign accept     = meas.valid && meas.ready;

	// Signed differences of the incoming measurement
	assign err_in  = signed'({1'b0, meas.measured_distance}) - signed'({1'b0, setpoint_q});
	assign diff_in = signed'({1'b0, meas.measured_distance}) - signed'({1'b0, prev_q});

	// Route the right difference and gain to the shared multiplier
	always_comb begin
		case (state_q)
			ST_MUL_P: begin
				mul_a = err_mag_q;
				mul_b = kp_q;
			end
			ST_MUL_I: begin
				mul_a = err_mag_q;
				mul_b = ki_q;
			end
			ST_MUL_D: begin
				mul_a = diff_mag_q;
				mul_b = kd_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidpc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign prod_mag      = conv_mag(prod);
	assign i_term        = to_term(prod_mag, err_neg_q);
	assign integral_next = ACC_W'(integral_q) + ACC_W'(i_term);
	assign total         = ACC_W'(p_q) + ACC_W'(integral_q) + ACC_W'(d_q);

	// Skip the divider entirely on a zero interval
	assign div_start = (state_q == ST_DIV_LOAD) && (ticks_q != '0);

	pidpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_mag),
		.divisor  (ticks_q),
		.done_q   (div_done),
		.quo_q    (quotient)
	);

	assign out_free = !out_valid_q || cmd.ready;

	assign cmd.valid         = out_valid_q;
	assign cmd.drive_value   = drive_q;
	assign cmd.zero_interval = zero_q;

	// Sequencer with its state registers and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			setpoint_q  <= SETPOINT_RST;
			kp_q        <= KP_RST;
			ki_q        <= KI_RST;
			kd_q        <= KD_RST;
			integral_q  <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load the output register from the final sum, else drop a taken result
			if ((state_q == ST_SUM) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SETPOINT: setpoint_q <= cfg_data[DIST_W-1:0];
					CFG_KP:       kp_q       <= cfg_data[GAIN_W-1:0];
					CFG_KI:       ki_q       <= cfg_data[GAIN_W-1:0];
					CFG_KD:       kd_q       <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: begin
					// Product holds the integral term now
					integral_q <= sat_out(integral_next);
					state_q    <= ST_DIV_LOAD;
				end
				ST_DIV_LOAD: begin
					state_q <= (ticks_q == '0) ? ST_SUM : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// Hold until the output register is free
					if (out_free) begin
						prev_q  <= meas_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q     <= meas.measured_distance;
			ticks_q    <= meas.elapsed_ticks;
			err_neg_q  <= err_in[DIST_W];
			err_mag_q  <= err_in[DIST_W] ? DIST_W'(-err_in) : err_in[DIST_W-1:0];
			diff_neg_q <= diff_in[DIST_W];
			diff_mag_q <= diff_in[DIST_W] ? DIST_W'(-diff_in) : diff_in[DIST_W-1:0];
		end
		if (state_q == ST_MUL_I) begin
			p_q <= to_term(prod_mag, err_neg_q);
		end
		if (state_q == ST_DIV_LOAD && ticks_q == '0) begin
			d_q <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			d_q <= to_term(quotient, diff_neg_q);
		end
		if (state_q == ST_SUM && out_free) begin
			drive_q <= sat_out(total);
			zero_q  <= (ticks_q == '0);
		end
	end

	// A request blocks further requests until its result is formed
	`PIDPC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !meas.ready)
	// A result only appears out of the final sum step
	`PIDPC_ASSERT(a_result_from_sum, clk, arst_n,
		!$rose(out_valid_q) || ($past(state_q) == ST_SUM))
	// A zero interval bypasses the divider
	`PIDPC_ASSERT_NEXT(a_zero_skips_div, clk, arst_n,
		(state_q == ST_DIV_LOAD) && (ticks_q == '0), state_q == ST_SUM)
	// The divider finishes only while the sequencer waits for it
	`PIDPC_ASSERT(a_div_done_in_div, clk, arst_n, !div_done || (state_q == ST_DIV))

endmodule

`default_nettype wire

// ===== rtl/core/pidpc_mul.sv =====
// Shared unsigned distance-by-gain multiplier with a registered product.
`default_nettype none

module pidpc_mul (
	input  wire logic                         clk,
	input  wire logic [pidpc_pkg::DIST_W-1:0] a,
	input  wire logic [pidpc_pkg::GAIN_W-1:0] b,
	output logic      [pidpc_pkg::PROD_W-1:0] prod_q
);
	import pidpc_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// ===== rtl/core/pidpc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pidpc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pidpc_pkg::MAG_W-1:0]   dividend,
	input  wire logic [pidpc_pkg::TICKS_W-1:0] divisor,
	output logic                               done_q,
	output logic      [pidpc_pkg::MAG_W-1:0]   quo_q
);
	import pidpc_pkg::*;

	logic [TICKS_W-1:0] rem_q;
	logic [TICKS_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [TICKS_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient in through one register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? TICKS_W'(trial - {1'b0, dvs_q}) : trial[TICKS_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_pid_position_controller.sv =====
// Self-checking testbench of the PID position controller: directed and random requests.
`timescale 1ns / 100ps

module tb_pid_position_controller;
	import pidpc_pkg::*;

	// Half of the 12 ns clock period.
	localparam int HALF_PERIOD = 6;
	// Generous ceiling on the cycle count of a run of roughly a thousand requests.
	localparam longint CYCLE_LIMIT = 1_000_000;
	// Long receiver hold-off that fills the block and stalls its request side.
	localparam int PRESSURE_HOLD = 300;
	// Cycles to keep watching after the last result, a bit more than the slowest request.
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_REQUESTS = 120;

	typedef struct {
		logic signed [OUT_W-1:0] drive_value;
		logic                    zero_interval;
	} drive_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pidpc_in_if  meas();
	pidpc_out_if cmd();

	pid_position_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas),
		.cmd       (cmd),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the controller: registers, integral and last distance.
	logic [DIST_W-1:0] setpoint_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;
	longint            integral_q;
	logic [DIST_W-1:0] prev_dist_q;

	// Drive values still owed by the block, oldest first.
	drive_result_t expected_drive_q[$];

	int unsigned error_count;
	longint      cycle_count;
	bit          offering;    // a request is held on meas.valid
	bit          steady;      // no request gaps, no new receiver stalls while set
	bit          hold_req;    // ask the receiver for a long hold-off
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Clamp to the signed 48-bit output range.
	function automatic longint clamp48(input longint v);
		if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
		if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
		return v;
	endfunction

	// gain * diff / div at the output fraction bits, magnitude truncated toward zero.
	function automatic longint gained_term(input logic [GAIN_W-1:0] gain, input longint diff,
			input longint unsigned div);
		bit                   neg;
		longint unsigned      mag;
		longint unsigned      q;
		neg = diff < 0;
		mag = longint'(neg ? -diff : diff) * longint'({40'd0, gain});
		if (GAIN_FRAC_BITS >= OUT_FRAC_BITS)
			q = mag / (div << (GAIN_FRAC_BITS - OUT_FRAC_BITS));
		else
			q = (mag << (OUT_FRAC_BITS - GAIN_FRAC_BITS)) / div;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// Advance the shadow controller by one measurement and return the drive it owes.
	function automatic drive_result_t predict_drive(input logic [DIST_W-1:0] distance,
			input logic [TICKS_W-1:0] ticks);
		drive_result_t res;
		longint        err;
		longint        slope;
		longint        p_term;
		longint        d_term;
		err    = longint'({48'd0, distance}) - longint'({48'd0, setpoint_q});
		slope  = longint'({48'd0, distance}) - longint'({48'd0, prev_dist_q});
		p_term = gained_term(kp_q, err, 1);
		integral_q = clamp48(integral_q + gained_term(ki_q, err, 1));
		// Zero interval: no derivative, raise the flag instead of dividing.
		d_term = (ticks == '0) ? 0 : gained_term(kd_q, slope, {40'd0, ticks});
		res.drive_value   = OUT_W'(clamp48(p_term + integral_q + d_term));
		res.zero_interval = (ticks == '0);
		prev_dist_q = distance;
		return res;
	endfunction

	// Half the time no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 17) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2, 3:    return GAIN_W'($urandom_range(1, 24'h1FFFF));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Offer one request, hold it until accepted, then log the drive it owes.
	task automatic send_measurement(input logic [DIST_W-1:0] distance,
			input logic [TICKS_W-1:0] ticks);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			if (offering)
				meas.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas.valid             <= 1'b1;
		meas.measured_distance <= distance;
		meas.elapsed_ticks     <= ticks;
		offering = 1'b1;
		do @(posedge clk); while (meas.ready !== 1'b1);
		expected_drive_q.push_back(predict_drive(distance, ticks));
	endtask

	task automatic send_random_measurement();
		logic [DIST_W-1:0]  distance;
		logic [TICKS_W-1:0] ticks;
		case ($urandom_range(0, 7))
			0:       distance = '0;
			1:       distance = '1;
			2:       distance = setpoint_q + DIST_W'($urandom_range(0, 8)) - DIST_W'(4);
			default: distance = DIST_W'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0:       ticks = '0;
			1:       ticks = '1;
			2, 3:    ticks = TICKS_W'($urandom_range(1, 16));
			default: ticks = TICKS_W'($urandom);
		endcase
		send_measurement(distance, ticks);
	endtask

	// Drop the request line and wait until every owed result has come back.
	task automatic wait_idle();
		if (offering)
			meas.valid <= 1'b0;
		offering = 1'b0;
		do @(posedge clk); while (expected_drive_q.size() != 0);
	endtask

	// One register write; call only while idle.
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SETPOINT: setpoint_q = value[DIST_W-1:0];
			CFG_KP:       kp_q = value[GAIN_W-1:0];
			CFG_KI:       ki_q = value[GAIN_W-1:0];
			CFG_KD:       kd_q = value[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	// Reset defaults: zero interval, error at the setpoint, extreme distances and ticks.
	task automatic test_reset_defaults();
		send_measurement('0, '0);
		send_measurement(16'd30, 24'd1);
		send_measurement('1, '1);
		send_measurement('0, 24'd1);
		send_measurement('1, '0);
		send_measurement(16'd12345, 24'd7);
		send_measurement(16'd30, 24'h800000);
		wait_idle();
	endtask

	// Register extremes: all gains off, then every gain and the setpoint at full scale.
	task automatic test_register_extremes();
		write_register(CFG_SETPOINT, '0);
		write_register(CFG_KP, '0);
		write_register(CFG_KI, '0);
		write_register(CFG_KD, '0);
		send_measurement('1, 24'd1);
		send_measurement('0, '0);
		wait_idle();

		write_register(CFG_SETPOINT, 24'hFFFF);
		write_register(CFG_KP, '1);
		write_register(CFG_KI, '1);
		write_register(CFG_KD, '1);
		// Largest rising slope over a single tick, largest fall over a zero interval.
		send_measurement('0, 24'd1);
		send_measurement('1, 24'd1);
		send_measurement('0, '0);
		send_measurement('1, '1);
		send_measurement(16'd1, 24'd2);
		send_measurement(16'hFFFE, 24'd3);
		wait_idle();
	endtask

	// Random settings per phase, random requests within; one phase runs with no idling.
	task automatic test_random_settings();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_register(CFG_SETPOINT, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
			write_register(CFG_KP, random_gain());
			write_register(CFG_KI, random_gain());
			write_register(CFG_KD, random_gain());
			steady = (phase == 1);
			repeat (PHASE_REQUESTS) send_random_measurement();
			wait_idle();
		end
		steady = 1'b0;
	endtask

	// Hold the result side off for a long stretch while requests keep coming.
	task automatic test_output_pressure();
		hold_req = 1'b1;
		while (hold_req) @(posedge clk);
		steady = 1'b1;
		repeat (8) send_random_measurement();
		steady = 1'b0;
		wait_idle();
	endtask

	// Push the integral into its positive clamp, then all the way down into the negative one.
	task automatic test_integral_saturation();
		write_register(CFG_SETPOINT, '0);
		write_register(CFG_KP, random_gain());
		write_register(CFG_KI, '1);
		write_register(CFG_KD, random_gain());
		repeat (150)
			send_measurement(16'hFFFF - DIST_W'($urandom_range(0, 15)), TICKS_W'($urandom));
		wait_idle();
		write_register(CFG_SETPOINT, 24'hFFFF);
		repeat (300)
			send_measurement(DIST_W'($urandom_range(0, 15)), TICKS_W'($urandom));
		wait_idle();
	endtask

	// Result side: random stalls, short mostly, plus the requested hold-off.
	initial begin : result_receiver
		cmd.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				stall_left = PRESSURE_HOLD;
				hold_req   = 1'b0;
			end
			if (stall_left > 0) begin
				cmd.ready <= 1'b0;
				stall_left--;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				cmd.ready <= 1'b1;
			end else begin
				cmd.ready <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// Compare each accepted result with the oldest owed drive.
	always @(posedge clk) begin : result_check
		drive_result_t want;
		if (arst_n === 1'b1 && cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
			if (expected_drive_q.size() == 0) begin
				$error("unexpected result: drive_value %0d", cmd.drive_value);
				error_count++;
			end else begin
				want = expected_drive_q.pop_front();
				if (cmd.drive_value !== want.drive_value) begin
					$error("drive_value: expected %0d, actual %0d",
						want.drive_value, cmd.drive_value);
					error_count++;
				end
				if (cmd.zero_interval !== want.zero_interval) begin
					$error("zero_interval: expected %0b, actual %0b",
						want.zero_interval, cmd.zero_interval);
					error_count++;
				end
			end
		end
	end

	initial begin : test_sequence
		arst_n                 <= 1'b0;
		meas.valid             <= 1'b0;
		meas.measured_distance <= '0;
		meas.elapsed_ticks     <= '0;
		cfg_wr_en              <= 1'b0;
		cfg_index              <= CFG_SETPOINT;
		cfg_data               <= '0;
		setpoint_q  = SETPOINT_RST;
		kp_q        = KP_RST;
		ki_q        = KI_RST;
		kd_q        = KD_RST;
		integral_q  = 0;
		prev_dist_q = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_random_settings();
		test_output_pressure();
		test_integral_saturation();

		// Drain: nothing owed, then watch a while for stray results.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
